### hdl/text_console_cursor_controller_defines.svh
// Assertion macros shared by the text console cursor controller RTL.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define TCCC_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("tccc: implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TCCC_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("tccc: next-cycle check failed");
`else
`define TCCC_ASSERT_IMP(lbl, ck, rn, a, c)
`define TCCC_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

### hdl/tccc_pkg.sv
// Types, codes and the microcode program of the text console cursor controller.
package tccc_pkg;

  localparam int WORK_W    = 17;  // cursor plus headroom for one step past the grid
  localparam int POS_W     = 16;
  localparam int DIV_CNT_W = 5;
  localparam int UA_W      = 5;

  typedef logic [WORK_W-1:0] work_t;

  // character codes
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_VT     = 8'd11;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] PRINT_MIN = 8'd32;

  // configuration register indexes
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_TAB  = 2'd2;

  localparam logic [7:0] COLS_RST = 8'd30;
  localparam logic [7:0] ROWS_RST = 8'd40;
  localparam logic [4:0] TAB_RST  = 5'd4;

  localparam logic KIND_DRAW  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // sequencing ops
  localparam logic [2:0] SQ_FETCH    = 3'd0;
  localparam logic [2:0] SQ_NEXT     = 3'd1;
  localparam logic [2:0] SQ_JUMP     = 3'd2;
  localparam logic [2:0] SQ_JCOND    = 3'd3;
  localparam logic [2:0] SQ_DISPATCH = 3'd4;
  localparam logic [2:0] SQ_DONE     = 3'd5;

  // jump conditions
  localparam logic C_ROW_OFF  = 1'b0;
  localparam logic C_COL_ZERO = 1'b1;

  // divider operand selects
  localparam logic [1:0] DS_POS    = 2'd0;  // cursor / columns
  localparam logic [1:0] DS_COLTAB = 2'd1;  // column / tab stop
  localparam logic [1:0] DS_CPCOLS = 2'd2;  // tab target column / columns

  // cursor ops
  localparam logic [3:0] WK_HOLD   = 4'd0;
  localparam logic [3:0] WK_INC    = 4'd1;
  localparam logic [3:0] WK_BS     = 4'd2;
  localparam logic [3:0] WK_ZERO   = 4'd3;
  localparam logic [3:0] WK_NL     = 4'd4;
  localparam logic [3:0] WK_CR     = 4'd5;
  localparam logic [3:0] WK_VT     = 4'd6;
  localparam logic [3:0] WK_TAB    = 4'd7;
  localparam logic [3:0] WK_TABFIX = 4'd8;
  localparam logic [3:0] WK_WRAP   = 4'd9;
  localparam logic [3:0] WK_COMMIT = 4'd10;

  // pending draw ops
  localparam logic [1:0] PD_NONE  = 2'd0;
  localparam logic [1:0] PD_GLYPH = 2'd1;
  localparam logic [1:0] PD_SPACE = 2'd2;

  // result emission ops
  localparam logic [1:0] EM_NONE  = 2'd0;
  localparam logic [1:0] EM_DRAW  = 2'd1;
  localparam logic [1:0] EM_CLEAR = 2'd2;

  // microcode addresses
  localparam logic [UA_W-1:0] UA_FETCH    = 5'd0;
  localparam logic [UA_W-1:0] UA_DIVPOS   = 5'd1;
  localparam logic [UA_W-1:0] UA_DISPATCH = 5'd2;
  localparam logic [UA_W-1:0] UA_PR_CHK   = 5'd3;
  localparam logic [UA_W-1:0] UA_PR_PEND  = 5'd4;
  localparam logic [UA_W-1:0] UA_PR_ADV   = 5'd5;
  localparam logic [UA_W-1:0] UA_BS_CHK   = 5'd6;
  localparam logic [UA_W-1:0] UA_BS_BACK  = 5'd7;
  localparam logic [UA_W-1:0] UA_BS_PEND  = 5'd8;
  localparam logic [UA_W-1:0] UA_FF       = 5'd9;
  localparam logic [UA_W-1:0] UA_LF       = 5'd10;
  localparam logic [UA_W-1:0] UA_CR       = 5'd11;
  localparam logic [UA_W-1:0] UA_VT       = 5'd12;
  localparam logic [UA_W-1:0] UA_TAB_DIV  = 5'd13;
  localparam logic [UA_W-1:0] UA_TAB_ADV  = 5'd14;
  localparam logic [UA_W-1:0] UA_TAB_DIV2 = 5'd15;
  localparam logic [UA_W-1:0] UA_TAB_FIX  = 5'd16;
  localparam logic [UA_W-1:0] UA_WRAP     = 5'd17;
  localparam logic [UA_W-1:0] UA_EMIT_D   = 5'd18;
  localparam logic [UA_W-1:0] UA_EMIT_C   = 5'd19;

  typedef struct packed {
    logic [2:0]      seq;
    logic            cond;
    logic [UA_W-1:0] target;
    logic            div_go;
    logic [1:0]      dsel;
    logic [3:0]      wop;
    logic [1:0]      pend;
    logic [1:0]      emit;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic       accept;
    logic       stall;
    logic       row_off;
    logic       col_zero;
    logic [7:0] chr;
  } seq_stat_t;

  localparam ucode_t UW_NOP = '{seq: SQ_NEXT, cond: C_ROW_OFF, target: UA_FETCH,
                                div_go: 1'b0, dsel: DS_POS, wop: WK_HOLD,
                                pend: PD_NONE, emit: EM_NONE};

  function automatic ucode_t ucode_rom(input logic [UA_W-1:0] pc);
    ucode_t uw;
    uw = UW_NOP;
    case (pc)
      UA_FETCH: uw.seq = SQ_FETCH;
      UA_DIVPOS: begin
        uw.div_go = 1'b1;
        uw.dsel   = DS_POS;
      end
      UA_DISPATCH: uw.seq = SQ_DISPATCH;
      UA_PR_CHK: begin
        uw.seq    = SQ_JCOND;
        uw.cond   = C_ROW_OFF;
        uw.target = UA_PR_ADV;
      end
      UA_PR_PEND: uw.pend = PD_GLYPH;
      UA_PR_ADV: begin
        uw.wop    = WK_INC;
        uw.seq    = SQ_JUMP;
        uw.target = UA_WRAP;
      end
      UA_BS_CHK: begin
        uw.seq    = SQ_JCOND;
        uw.cond   = C_COL_ZERO;
        uw.target = UA_WRAP;
      end
      UA_BS_BACK: begin
        uw.wop    = WK_BS;
        uw.seq    = SQ_JCOND;
        uw.cond   = C_ROW_OFF;
        uw.target = UA_WRAP;
      end
      UA_BS_PEND: begin
        uw.pend   = PD_SPACE;
        uw.seq    = SQ_JUMP;
        uw.target = UA_WRAP;
      end
      UA_FF: begin
        uw.wop    = WK_ZERO;
        uw.seq    = SQ_JUMP;
        uw.target = UA_WRAP;
      end
      UA_LF: begin
        uw.wop    = WK_NL;
        uw.seq    = SQ_JUMP;
        uw.target = UA_WRAP;
      end
      UA_CR: begin
        uw.wop    = WK_CR;
        uw.seq    = SQ_JUMP;
        uw.target = UA_WRAP;
      end
      UA_VT: begin
        uw.wop    = WK_VT;
        uw.seq    = SQ_JUMP;
        uw.target = UA_WRAP;
      end
      UA_TAB_DIV: begin
        uw.div_go = 1'b1;
        uw.dsel   = DS_COLTAB;
      end
      UA_TAB_ADV: uw.wop = WK_TAB;
      UA_TAB_DIV2: begin
        uw.div_go = 1'b1;
        uw.dsel   = DS_CPCOLS;
      end
      UA_TAB_FIX: uw.wop = WK_TABFIX;
      UA_WRAP: uw.wop = WK_WRAP;
      UA_EMIT_D: uw.emit = EM_DRAW;
      UA_EMIT_C: begin
        uw.emit = EM_CLEAR;
        uw.wop  = WK_COMMIT;
        uw.seq  = SQ_DONE;
      end
      default: uw.seq = SQ_DONE;
    endcase
    return uw;
  endfunction

  // entry point of the routine for one character code
  function automatic logic [UA_W-1:0] dispatch(input logic [7:0] chr);
    logic [UA_W-1:0] ua;
    if (chr >= PRINT_MIN) begin
      ua = UA_PR_CHK;
    end else begin
      case (chr)
        CH_BS:   ua = UA_BS_CHK;
        CH_TAB:  ua = UA_TAB_DIV;
        CH_LF:   ua = UA_LF;
        CH_VT:   ua = UA_VT;
        CH_FF:   ua = UA_FF;
        CH_CR:   ua = UA_CR;
        default: ua = UA_WRAP;
      endcase
    end
    return ua;
  endfunction

endpackage

### hdl/tccc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module tccc_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  tccc_pkg::work_t        num,
  input  logic [7:0]             den,
  output logic                   busy,
  output logic                   done,
  output tccc_pkg::work_t        quot,
  output logic [7:0]             rem
);

  logic                               busy_r;
  logic                               done_r;
  logic [tccc_pkg::DIV_CNT_W-1:0]     cnt_r;
  tccc_pkg::work_t                    q_r;
  logic [7:0]                         r_r;
  logic [7:0]                         den_r;
  logic [8:0]                         trial;
  logic                               ge;
  logic [8:0]                         diff;

  always_comb begin
    trial = {r_r, q_r[tccc_pkg::WORK_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= tccc_pkg::DIV_CNT_W'(tccc_pkg::WORK_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - tccc_pkg::DIV_CNT_W'(1);
      if (cnt_r == tccc_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      r_r   <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r <= {q_r[tccc_pkg::WORK_W-2:0], ge};
      r_r <= ge ? diff[7:0] : trial[7:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

### hdl/tccc_seq.sv
// Microcode sequencer: step counter, control store lookup and jumps.
module tccc_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  tccc_pkg::seq_stat_t stat,
  output tccc_pkg::ucode_t    ctl
);

  logic [tccc_pkg::UA_W-1:0] pc_r;
  logic [tccc_pkg::UA_W-1:0] pc_nxt;
  logic [tccc_pkg::UA_W-1:0] pc_inc;
  tccc_pkg::ucode_t          uw;
  logic                      cond_true;

  always_comb begin
    uw        = tccc_pkg::ucode_rom(pc_r);
    pc_inc    = pc_r + tccc_pkg::UA_W'(1);
    cond_true = (uw.cond == tccc_pkg::C_ROW_OFF) ? stat.row_off : stat.col_zero;
    pc_nxt    = pc_r;
    if (uw.seq == tccc_pkg::SQ_FETCH) begin
      if (stat.accept) begin
        pc_nxt = tccc_pkg::UA_DIVPOS;
      end
    end else if (!stat.stall) begin
      case (uw.seq)
        tccc_pkg::SQ_NEXT:     pc_nxt = pc_inc;
        tccc_pkg::SQ_JUMP:     pc_nxt = uw.target;
        tccc_pkg::SQ_JCOND:    pc_nxt = cond_true ? uw.target : pc_inc;
        tccc_pkg::SQ_DISPATCH: pc_nxt = tccc_pkg::dispatch(stat.chr);
        tccc_pkg::SQ_DONE:     pc_nxt = tccc_pkg::UA_FETCH;
        default:               pc_nxt = tccc_pkg::UA_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tccc_pkg::UA_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl = uw;

endmodule

### hdl/text_console_cursor_controller.sv
// Top level of the text console cursor controller: datapath, config and result register.
// The block takes one character byte per request and keeps a linear cursor
// (row * columns + column) into a text grid of text_columns by text_rows cells.
// Printable bytes give a draw-glyph result at the cursor cell; backspace gives
// a draw of a space one cell back unless the column is 0; form feed, newline,
// carriage return, horizontal and vertical tab only move the cursor; other
// control bytes do nothing. Whenever a step leaves the cursor at or past the
// end of the grid it returns to 0 and a clear-screen result follows, so a
// request yields zero, one or two results, the final one flagged by last. A
// column, row or tab size written as 0 acts as 1. One request is worked on at
// a time: a microcoded sequencer steps through a short routine per character
// and shares one bit-serial divider for every division; a division holds its
// step while the divider is started, shifts out 17 quotient bits and hands
// the result back. A horizontal tab needs three divisions, and a request can
// also wait for the result side to take a result. A finished result sits in
// the output register while the next request is taken. Configuration writes
// go straight into the configuration registers and are meant only while no
// request is in flight.
`include "text_console_cursor_controller_defines.svh"

module text_console_cursor_controller (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // character requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  // drawing commands
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_glyph_code,
  output logic [7:0] out_text_row,
  output logic [7:0] out_text_col,
  output logic       out_last
);

  // configuration
  logic [7:0]                   cols_r;
  logic [7:0]                   rows_r;
  logic [4:0]                   tab_r;
  logic [7:0]                   cols_eff;
  logic [7:0]                   rows_eff;
  logic [4:0]                   tab_eff;
  logic [tccc_pkg::POS_W-1:0]   prod_r;

  // cursor and working registers
  logic [tccc_pkg::POS_W-1:0]   pos_r;
  tccc_pkg::work_t              work_r;
  tccc_pkg::work_t              work_nxt;
  logic [7:0]                   chr_r;
  tccc_pkg::work_t              row_r;
  logic [7:0]                   col_r;
  logic [7:0]                   tmp_r;
  logic [8:0]                   cp_r;
  logic                         pend_r;
  logic [7:0]                   pend_glyph_r;
  logic                         wrap_r;
  logic                         wrap_now;

  // divider handshake
  logic                         div_run_r;
  logic                         div_start;
  logic                         div_wait;
  logic                         div_busy;
  logic                         div_done;
  logic                         div_take;
  tccc_pkg::work_t              div_num;
  logic [7:0]                   div_den;
  tccc_pkg::work_t              div_quot;
  logic [7:0]                   div_rem;

  // sequencer
  tccc_pkg::ucode_t             ctl;
  tccc_pkg::seq_stat_t          stat;
  logic                         accept;
  logic                         stall;
  logic                         step_go;

  // result register
  logic                         out_valid_r;
  logic                         out_kind_r;
  logic [7:0]                   out_glyph_r;
  logic [7:0]                   out_row_r;
  logic [7:0]                   out_col_r;
  logic                         out_last_r;
  logic                         emit_fire;
  logic                         emit_block;
  logic                         out_load;

  // A size of 0 behaves as 1.
  assign cols_eff = (cols_r == 8'd0) ? 8'd1 : cols_r;
  assign rows_eff = (rows_r == 8'd0) ? 8'd1 : rows_r;
  assign tab_eff  = (tab_r == 5'd0) ? 5'd1 : tab_r;

  tccc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Take a request only while the sequencer sits at its fetch step.
  assign in_ready = (ctl.seq == tccc_pkg::SQ_FETCH);
  assign accept   = in_valid && in_ready;

  // Divider operand select: the control word picks the division.
  always_comb begin
    case (ctl.dsel)
      tccc_pkg::DS_COLTAB: begin
        div_num = tccc_pkg::work_t'(col_r);
        div_den = {3'd0, tab_eff};
      end
      tccc_pkg::DS_CPCOLS: begin
        div_num = tccc_pkg::work_t'(cp_r);
        div_den = cols_eff;
      end
      default: begin
        div_num = work_r;
        div_den = cols_eff;
      end
    endcase
  end

  // A division step starts the divider once, then holds until it reports done.
  assign div_start = ctl.div_go && !div_run_r;
  assign div_take  = ctl.div_go && div_run_r && div_done;
  assign div_wait  = ctl.div_go && !div_take;

  tccc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Emit steps only fire when they have something to send; hold the step
  // while the result register is still occupied.
  assign emit_fire  = ((ctl.emit == tccc_pkg::EM_DRAW) && pend_r) ||
                      ((ctl.emit == tccc_pkg::EM_CLEAR) && wrap_r);
  assign emit_block = emit_fire && out_valid_r && !out_ready;
  assign out_load   = emit_fire && !emit_block;

  assign stall   = div_wait || emit_block;
  assign step_go = !stall && (ctl.seq != tccc_pkg::SQ_FETCH);

  assign stat.accept   = accept;
  assign stat.stall    = stall;
  assign stat.row_off  = row_r >= tccc_pkg::work_t'(rows_eff);
  assign stat.col_zero = (col_r == 8'd0);
  assign stat.chr      = chr_r;

  assign wrap_now = work_r >= tccc_pkg::work_t'(prod_r);

  // Cursor arithmetic for the current step.
  always_comb begin
    case (ctl.wop)
      tccc_pkg::WK_INC:  work_nxt = work_r + tccc_pkg::work_t'(1);
      tccc_pkg::WK_BS:   work_nxt = work_r - tccc_pkg::work_t'(1);
      tccc_pkg::WK_ZERO: work_nxt = '0;
      // next line: drop the column, add a full line
      tccc_pkg::WK_NL:   work_nxt = work_r - tccc_pkg::work_t'(col_r) +
                                    tccc_pkg::work_t'(cols_eff);
      tccc_pkg::WK_CR:   work_nxt = work_r - tccc_pkg::work_t'(col_r);
      tccc_pkg::WK_VT:   work_nxt = work_r + tccc_pkg::work_t'(cols_eff);
      // advance to the next tab stop; tmp holds column mod tab
      tccc_pkg::WK_TAB:  work_nxt = work_r + tccc_pkg::work_t'(tab_eff) -
                                    tccc_pkg::work_t'(tmp_r);
      // landed near the start of a following line: snap to its column 0
      tccc_pkg::WK_TABFIX: begin
        if (tmp_r < {3'd0, tab_eff}) begin
          work_nxt = work_r - tccc_pkg::work_t'(tmp_r);
        end else begin
          work_nxt = work_r;
        end
      end
      tccc_pkg::WK_WRAP: work_nxt = wrap_now ? '0 : work_r;
      default:           work_nxt = work_r;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= tccc_pkg::COLS_RST;
      rows_r      <= tccc_pkg::ROWS_RST;
      tab_r       <= tccc_pkg::TAB_RST;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      wrap_r      <= 1'b0;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tccc_pkg::CFG_COLS: cols_r <= cfg_wdata;
          tccc_pkg::CFG_ROWS: rows_r <= cfg_wdata;
          tccc_pkg::CFG_TAB:  tab_r  <= cfg_wdata[4:0];
          default: ;
        endcase
      end

      if (div_start) begin
        div_run_r <= 1'b1;
      end else if (div_take) begin
        div_run_r <= 1'b0;
      end

      if (accept) begin
        pend_r <= 1'b0;
        wrap_r <= 1'b0;
      end else if (step_go) begin
        if (ctl.pend != tccc_pkg::PD_NONE) begin
          pend_r <= 1'b1;
        end
        if (ctl.wop == tccc_pkg::WK_WRAP) begin
          wrap_r <= wrap_now;
        end
        if (ctl.wop == tccc_pkg::WK_COMMIT) begin
          pos_r <= work_r[tccc_pkg::POS_W-1:0];
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working payload.
  always_ff @(posedge clk) begin
    prod_r <= {8'd0, cols_eff} * {8'd0, rows_eff};
    if (accept) begin
      chr_r  <= in_char_code;
      work_r <= tccc_pkg::work_t'(pos_r);
    end else if (step_go) begin
      work_r <= work_nxt;
    end

    if (div_take) begin
      if (ctl.dsel == tccc_pkg::DS_POS) begin
        row_r <= div_quot;
        col_r <= div_rem;
      end else begin
        tmp_r <= div_rem;
      end
    end else if (step_go && (ctl.wop == tccc_pkg::WK_BS)) begin
      col_r <= col_r - 8'd1;
    end

    if (step_go && (ctl.wop == tccc_pkg::WK_TAB)) begin
      cp_r <= {1'b0, col_r} + {4'd0, tab_eff} - {1'b0, tmp_r};
    end

    if (step_go && (ctl.pend == tccc_pkg::PD_GLYPH)) begin
      pend_glyph_r <= chr_r;
    end else if (step_go && (ctl.pend == tccc_pkg::PD_SPACE)) begin
      pend_glyph_r <= tccc_pkg::CH_SPACE;
    end

    // Load the result register: a draw is last unless a clear follows.
    if (out_load) begin
      if (ctl.emit == tccc_pkg::EM_CLEAR) begin
        out_kind_r  <= tccc_pkg::KIND_CLEAR;
        out_glyph_r <= 8'd0;
        out_row_r   <= 8'd0;
        out_col_r   <= 8'd0;
        out_last_r  <= 1'b1;
      end else begin
        out_kind_r  <= tccc_pkg::KIND_DRAW;
        out_glyph_r <= pend_glyph_r;
        out_row_r   <= row_r[7:0];
        out_col_r   <= col_r;
        out_last_r  <= !wrap_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_glyph_code = out_glyph_r;
  assign out_text_row   = out_row_r;
  assign out_text_col   = out_col_r;
  assign out_last       = out_last_r;

  // The sequencer must never restart the divider while it is still iterating.
  `TCCC_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_start, !div_busy)
  // A clear is always the final result of its request and carries zeros.
  `TCCC_ASSERT_IMP(a_clear_fields, clk, rst_n, out_valid_r && (out_kind_r == tccc_pkg::KIND_CLEAR), out_last_r && (out_glyph_r == 8'd0) && (out_row_r == 8'd0) && (out_col_r == 8'd0))
  // After the wrap step a pending clear means the cursor went home.
  `TCCC_ASSERT_NXT(a_wrap_home, clk, rst_n, ctl.wop == tccc_pkg::WK_WRAP, !wrap_r || (work_r == '0))

endmodule
